// File: design/bpc_pkg.sv
// bpc_pkg: shared constants for the block permutation cipher
// field widths, command codes, pad byte and the default block limit
// no dependencies
package bpc_pkg;

    localparam int MAX_BLOCK_DEF = 64;
    localparam int SIZE_W        = 7;
    localparam int KEY_W         = 6;
    localparam int BYTE_W        = 8;
    localparam int CMP_W         = 9;
    localparam int KEY_RANGE     = 64;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h20;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

endpackage

// File: design/bpc_ram.sv
// bpc_ram: generic single-port-write, single-port-read RAM
// read data is registered and updates only while read is enabled
// no dependencies
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/block_permutation_cipher.sv
// block_permutation_cipher: a key load is accepted in idle; a data byte passes key lookup, then buffer write
// a completing byte starts emission of effective block size bytes at one per cycle while the receiver keeps up;
// an end of message on a partial block first adds a pad pass over the remaining slots
// reset clears control state, block_size to 64 and fill to zero; key and buffer undefined
// depends on bpc_pkg and bpc_ram
module block_permutation_cipher #(
    parameter int MAX_BLOCK = bpc_pkg::MAX_BLOCK_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic [bpc_pkg::KEY_W-1:0]  i_key_pos,
    input  logic [bpc_pkg::KEY_W-1:0]  i_key_value,
    input  logic [bpc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_end_of_message,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bpc_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_block_last,
    input  logic                       i_cfg_we,
    input  logic [bpc_pkg::SIZE_W-1:0] i_cfg_wdata
);

    import bpc_pkg::*;

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PLACE = 2'd1;
    localparam logic [1:0] S_PAD   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_fill, n_fill;
    logic [SIZE_W-1:0] r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_eom, n_eom;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic [SIZE_W-1:0] eff;
    logic              in_acc;
    logic              pad_iss;
    logic              emit_iss;
    logic              load;

    logic [AW-1:0]     w_slot_tab [KEY_RANGE];

    logic              key_we;
    logic [AW-1:0]     key_waddr;
    logic              key_re;
    logic [AW-1:0]     key_raddr;
    logic [AW-1:0]     key_rdata;
    logic              buf_we;
    logic [BYTE_W-1:0] buf_wdata;
    logic [BYTE_W-1:0] buf_rdata;

    // key value reduced to a slot number
    for (genvar g = 0; g < KEY_RANGE; g++) begin : g_slot
        assign w_slot_tab[g] = AW'(g % MAX_BLOCK);
    end

    // effective block size
    always_comb begin
        priority if (r_size == '0) begin
            eff = SIZE_W'(1);
        end else if (CMP_W'(r_size) > CMP_W'(MAX_BLOCK)) begin
            eff = SIZE_W'(MAX_BLOCK);
        end else begin
            eff = r_size;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign pad_iss  = (r_state == S_PAD) && (r_idx < eff);
    assign load     = (r_state == S_EMIT) && r_pend && (!r_out_vld || i_ready);
    assign emit_iss = (r_state == S_EMIT) && (r_idx < eff) && (!r_pend || load);

    assign key_we    = in_acc && (i_cmd == CMD_KEY) && (CMP_W'(i_key_pos) < CMP_W'(MAX_BLOCK));
    assign key_waddr = AW'(i_key_pos);
    assign key_re    = (in_acc && (i_cmd == CMD_DATA)) || pad_iss;
    assign key_raddr = (r_state == S_IDLE) ? AW'(r_fill) : AW'(r_idx);

    assign buf_we    = (r_state == S_PLACE) || ((r_state == S_PAD) && r_pend);
    assign buf_wdata = (r_state == S_PLACE) ? r_byte : PAD_BYTE;

    bpc_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_BLOCK)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (w_slot_tab[i_key_value]),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    bpc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BLOCK)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (key_rdata),
        .i_wdata (buf_wdata),
        .i_re    (emit_iss),
        .i_raddr (AW'(r_idx)),
        .o_rdata (buf_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_byte  = r_byte;
        n_eom   = r_eom;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_DATA)) begin
                    n_fill  = r_fill + SIZE_W'(1);
                    n_byte  = i_data_byte;
                    n_eom   = i_end_of_message;
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                n_pend = 1'b0;
                priority if ((r_fill < eff) && !r_eom) begin
                    n_state = S_IDLE;
                end else if (r_fill < eff) begin
                    n_idx   = r_fill;
                    n_state = S_PAD;
                end else begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_PAD: begin
                n_pend = pad_iss;
                if (pad_iss) begin
                    n_idx = r_idx + SIZE_W'(1);
                end else begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_pend = emit_iss || (r_pend && !load);
                if (emit_iss) begin
                    n_idx = r_idx + SIZE_W'(1);
                end
                if ((r_idx == eff) && !r_pend) begin
                    n_fill  = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size    <= SIZE_W'(64);
            r_fill    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_eom  <= n_eom;
        if (load) begin
            r_out_byte <= buf_rdata;
            r_out_last <= (r_idx == eff);
        end
    end

    assign o_valid      = r_out_vld;
    assign o_out_byte   = r_out_byte;
    assign o_block_last = r_out_last;

    // read pending only while padding or emitting
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_PAD || r_state == S_EMIT))
        else $error("read pending outside pad or emit");

    // a buffer write lasts exactly one cycle per data request
    a_place_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |=> (r_state != S_PLACE))
        else $error("place state held twice");

    // emission index never runs past the block
    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx <= eff))
        else $error("emit index past block size");

    // a full emission returns to idle with an empty block
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && (r_idx == eff) && !r_pend)
        |=> ((r_state == S_IDLE) && (r_fill == '0)))
        else $error("emission did not finish cleanly");

    // output register only loads when it is free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |-> !load)
        else $error("stalled output overwritten");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for block_permutation_cipher, a directed table then random
// key loads and messages, results checked against table bytes or an in-bench predictor
// depends on bpc_pkg and the block_permutation_cipher design sources
module tb_top;
    import bpc_pkg::*;

    localparam int LIMIT_CYC = 800000;
    localparam int DRAIN_GAP = 20;
    localparam int HOLD_CYC  = 400;
    localparam int N_DIR     = 23;
    localparam int PHASE_ITEMS = 40;

    typedef enum logic [1:0] {ROW_CFG, ROW_KEY, ROW_DATA} t_row_kind;
    typedef enum int {KEYS_KEEP, KEYS_MIXED, KEYS_PERM} t_key_mode;

    typedef struct packed {
        t_row_kind         kind;
        logic [SIZE_W-1:0] size;
        logic [KEY_W-1:0]  pos;
        logic [KEY_W-1:0]  val;
        logic [BYTE_W-1:0] data;
        logic              eom;
        logic              typed;
        logic [BYTE_W-1:0] exp_byte;
    } t_dir_row;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              i_cmd            = CMD_KEY;
    logic [KEY_W-1:0]  i_key_pos        = '0;
    logic [KEY_W-1:0]  i_key_value      = '0;
    logic [BYTE_W-1:0] i_data_byte      = '0;
    logic              i_end_of_message = 1'b0;
    logic              i_ready          = 1'b0;
    logic              i_cfg_we         = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata      = '0;
    logic              o_ready;
    logic              o_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_block_last;

    // predictor state
    logic [KEY_W-1:0]  key_map  [KEY_RANGE];
    logic [BYTE_W-1:0] perm_buf [KEY_RANGE];
    logic [SIZE_W-1:0] fill_cnt = '0;
    logic [SIZE_W-1:0] size_reg = 7'd64;

    logic [BYTE_W-1:0] exp_byte_q [$];
    logic              exp_last_q [$];

    t_dir_row dir_tab [N_DIR];

    int err_cnt   = 0;
    int cycles    = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_ask  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rnd_items = 0;

    logic [BYTE_W-1:0] got_byte;
    logic              got_last;

    block_permutation_cipher u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_key_pos        (i_key_pos),
        .i_key_value      (i_key_value),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_block_last     (o_block_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int eff_size();
        int n;
        n = int'(size_reg);
        if (n == 0) n = 1;
        if (n > MAX_BLOCK_DEF) n = MAX_BLOCK_DEF;
        return n;
    endfunction

    function automatic void place_byte(input int pos, input logic [BYTE_W-1:0] b);
        perm_buf[key_map[pos % KEY_RANGE]] = b;
    endfunction

    function automatic void cipher_step(input logic cmd, input logic [KEY_W-1:0] pos,
                                        input logic [KEY_W-1:0] val,
                                        input logic [BYTE_W-1:0] dat, input logic eom,
                                        input logic quiet);
        int n;
        if (cmd == CMD_KEY) begin
            key_map[pos] = val;
            return;
        end
        n = eff_size();
        place_byte(int'(fill_cnt), dat);
        fill_cnt = fill_cnt + SIZE_W'(1);
        if (int'(fill_cnt) < n && !eom) return;
        for (int j = int'(fill_cnt); j < n; j++) place_byte(j, PAD_BYTE);
        if (!quiet) begin
            for (int j = 0; j < n; j++) begin
                exp_byte_q.push_back(perm_buf[j]);
                exp_last_q.push_back(j == n - 1);
            end
        end
        fill_cnt = '0;
    endfunction

    function automatic t_dir_row mk_row(input t_row_kind kind, input int size, input int pos,
                                        input int val, input int data, input bit eom,
                                        input bit typed, input int exp_byte);
        t_dir_row r;
        r.kind     = kind;
        r.size     = size[SIZE_W-1:0];
        r.pos      = pos[KEY_W-1:0];
        r.val      = val[KEY_W-1:0];
        r.data     = data[BYTE_W-1:0];
        r.eom      = eom;
        r.typed    = typed;
        r.exp_byte = exp_byte[BYTE_W-1:0];
        return r;
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 12) return 1;
        if (r < 15) return $urandom_range(127, 9);
        if (r < 17) return 64;
        return $urandom_range(8, 2);
    endfunction

    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] pos,
                             input logic [KEY_W-1:0] val, input logic [BYTE_W-1:0] dat,
                             input logic eom);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid          <= 1'b1;
        i_cmd            <= cmd;
        i_key_pos        <= pos;
        i_key_value      <= val;
        i_data_byte      <= dat;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic push_item(input logic cmd, input logic [KEY_W-1:0] pos,
                             input logic [KEY_W-1:0] val, input logic [BYTE_W-1:0] dat,
                             input logic eom);
        send_item(cmd, pos, val, dat, eom);
        cipher_step(cmd, pos, val, dat, eom, 1'b0);
        rnd_items++;
    endtask

    task automatic push_rnd_key();
        push_item(CMD_KEY, KEY_W'($urandom), KEY_W'($urandom), BYTE_W'($urandom),
                  1'($urandom));
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (exp_byte_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = v;
    endtask

    task automatic load_perm(input int n);
        int perm  [KEY_RANGE];
        int order [KEY_RANGE];
        int k;
        int t;
        for (int i = 0; i < n; i++) begin
            perm[i]  = i;
            order[i] = i;
        end
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(i);
            t = perm[i];
            perm[i] = perm[k];
            perm[k] = t;
            k = $urandom_range(i);
            t = order[i];
            order[i] = order[k];
            order[k] = t;
        end
        for (int i = 0; i < n; i++)
            push_item(CMD_KEY, KEY_W'(order[i]), KEY_W'(perm[order[i]]), BYTE_W'($urandom),
                      1'($urandom));
    endtask

    task automatic run_segment(input int sz, input int msg_len, input t_key_mode keys,
                               input bit hold);
        int n;
        int len;
        logic eom;
        write_size(sz[SIZE_W-1:0]);
        n = eff_size();
        if (keys == KEYS_PERM || (keys == KEYS_MIXED && $urandom_range(99) < 85))
            load_perm(n);
        else if (keys == KEYS_MIXED)
            repeat ($urandom_range(4, 1)) push_rnd_key();
        if (hold) hold_ask++;
        len = msg_len;
        if (len == 0) len = (n <= 8) ? $urandom_range(3 * n + 2, 1) : $urandom_range(n + 4, 1);
        for (int i = 0; i < len; i++) begin
            if (keys == KEYS_MIXED && $urandom_range(99) < 6)
                push_rnd_key();
            eom = (i == len - 1) ? ($urandom_range(99) < 75) : ($urandom_range(99) < 4);
            push_item(CMD_DATA, KEY_W'($urandom), KEY_W'($urandom), BYTE_W'($urandom), eom);
        end
    endtask

    // receiver side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYC;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_byte_q.size() == 0) begin
                $display("%0t: unexpected result, byte %02h last %0b", $time, o_out_byte,
                         o_block_last);
                err_cnt++;
            end else begin
                got_byte = exp_byte_q.pop_front();
                got_last = exp_last_q.pop_front();
                if (o_out_byte !== got_byte) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time, got_byte,
                             o_out_byte);
                    err_cnt++;
                end
                if (o_block_last !== got_last) begin
                    $display("%0t: block_last expected %0b actual %0b", $time, got_last,
                             o_block_last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYC) begin
            $display("%0t: timeout, %0d results outstanding", $time, exp_byte_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_dir_row row;
        int base;
        // block size one: results readable directly
        dir_tab[0]  = mk_row(ROW_CFG,  1,  0,  0, 8'h00, 0, 0, 8'h00);
        dir_tab[1]  = mk_row(ROW_KEY,  0,  0,  0, 8'hff, 1, 0, 8'h00);
        dir_tab[2]  = mk_row(ROW_DATA, 0, 63, 63, 8'h00, 0, 1, 8'h00);
        dir_tab[3]  = mk_row(ROW_DATA, 0,  0,  0, 8'hff, 1, 1, 8'hff);
        // slot outside the block, old byte comes out
        dir_tab[4]  = mk_row(ROW_KEY,  0,  0, 63, 8'h00, 0, 0, 8'h00);
        dir_tab[5]  = mk_row(ROW_DATA, 0,  0,  0, 8'h5a, 0, 1, 8'hff);
        dir_tab[6]  = mk_row(ROW_KEY,  0,  0,  0, 8'h00, 0, 0, 8'h00);
        // zero size acts as one
        dir_tab[7]  = mk_row(ROW_CFG,  0,  0,  0, 8'h00, 0, 0, 8'h00);
        dir_tab[8]  = mk_row(ROW_DATA, 0,  0,  0, 8'ha5, 0, 1, 8'ha5);
        // reversing key, full block then padded block
        dir_tab[9]  = mk_row(ROW_CFG,  4,  0,  0, 8'h00, 0, 0, 8'h00);
        dir_tab[10] = mk_row(ROW_KEY,  0,  0,  3, 8'h00, 0, 0, 8'h00);
        dir_tab[11] = mk_row(ROW_KEY,  0,  1,  2, 8'h00, 0, 0, 8'h00);
        dir_tab[12] = mk_row(ROW_KEY,  0,  2,  1, 8'h00, 0, 0, 8'h00);
        dir_tab[13] = mk_row(ROW_KEY,  0,  3,  0, 8'h00, 0, 0, 8'h00);
        dir_tab[14] = mk_row(ROW_DATA, 0, 63, 63, 8'h61, 0, 0, 8'h00);
        dir_tab[15] = mk_row(ROW_DATA, 0,  0,  0, 8'h62, 0, 0, 8'h00);
        dir_tab[16] = mk_row(ROW_DATA, 0, 21, 42, 8'h63, 0, 0, 8'h00);
        dir_tab[17] = mk_row(ROW_DATA, 0,  0,  0, 8'h64, 0, 0, 8'h00);
        dir_tab[18] = mk_row(ROW_DATA, 0,  0,  0, 8'h41, 1, 0, 8'h00);
        // size shrinks mid-block
        dir_tab[19] = mk_row(ROW_DATA, 0,  0,  0, 8'h10, 0, 0, 8'h00);
        dir_tab[20] = mk_row(ROW_DATA, 0,  0,  0, 8'h20, 0, 0, 8'h00);
        dir_tab[21] = mk_row(ROW_CFG,  2,  0,  0, 8'h00, 0, 0, 8'h00);
        dir_tab[22] = mk_row(ROW_DATA, 0,  0,  0, 8'h30, 0, 0, 8'h00);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 28;
        recv_idle = 74;
        for (int r = 0; r < N_DIR; r++) begin
            row = dir_tab[r];
            if (row.kind == ROW_CFG) begin
                write_size(row.size);
            end else begin
                send_item((row.kind == ROW_DATA) ? CMD_DATA : CMD_KEY, row.pos, row.val,
                          row.data, row.eom);
                cipher_step((row.kind == ROW_DATA) ? CMD_DATA : CMD_KEY, row.pos, row.val,
                            row.data, row.eom, row.typed);
                if (row.typed) begin
                    exp_byte_q.push_back(row.exp_byte);
                    exp_last_q.push_back(1'b1);
                end
            end
        end

        // full-size block writes every key entry and buffer slot
        run_segment(64, 64, KEYS_PERM, 1'b0);
        run_segment(127, 5, KEYS_KEEP, 1'b0);

        base = rnd_items;
        for (int m = 0; m < 3; m++) begin
            send_idle = (m == 0) ? 28 : (m == 1) ? 74 : 0;
            recv_idle = (m == 0) ? 74 : (m == 1) ? 28 : 0;
            if (m == 2) run_segment(4, 24, KEYS_PERM, 1'b1);
            while (rnd_items < base + (m + 1) * PHASE_ITEMS)
                run_segment(pick_size(), 0, KEYS_MIXED, 1'b0);
        end

        wait_drain();
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
